>>> rtl/vfzm_pkg.sv
package vfzm_pkg;

   localparam int DimW     = 16;
   localparam int ZoomW    = 23;
   localparam int PanW     = 40;
   localparam int ScaleW   = 32;
   localparam int OutW     = 48;
   localparam int WideW    = 50;
   localparam int DivSteps = 16;

   localparam logic [ZoomW-1:0] ZoomMin = 23'd1024;
   localparam logic [ZoomW-1:0] ZoomMax = 23'd4194304;
   localparam logic [ScaleW-1:0] OneQ16 = 32'd65536;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      MODE_FIT  = 1'b0,
      MODE_ZOOM = 1'b1
   } mode_type;

   typedef struct packed {
      logic [DimW-1:0]        canv_w;
      logic [DimW-1:0]        canv_h;
      logic [DimW-1:0]        tgt_w;
      logic [DimW-1:0]        tgt_h;
      mode_type               view_mode;
      logic [ZoomW-1:0]       zoom_q16;
      logic signed [PanW-1:0] pan_x_q16;
      logic signed [PanW-1:0] pan_y_q16;
      logic                   invalid;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [ScaleW-1:0]      scale_q16;
      logic signed [OutW-1:0] dest_left_q16;
      logic signed [OutW-1:0] dest_top_q16;
      logic [OutW-1:0]        dest_width_q16;
      logic [OutW-1:0]        dest_height_q16;
      logic                   needs_intermediate;
   } rsp_type;

   // two restoring division steps: result is {quotient bits, remainder}
   function automatic logic [DimW+1:0] div_step2(input logic [DimW-1:0] rem,
                                                 input logic [1:0] bits,
                                                 input logic [DimW-1:0] dvs);
      logic [DimW:0] r;
      logic [1:0]    q;
      r = {rem, bits[1]};
      q[1] = (r >= {1'b0, dvs});
      if (q[1]) begin
         r = r - {1'b0, dvs};
      end
      r = {r[DimW-1:0], bits[0]};
      q[0] = (r >= {1'b0, dvs});
      if (q[0]) begin
         r = r - {1'b0, dvs};
      end
      return {q, r[DimW-1:0]};
   endfunction

endpackage

>>> rtl/vfzm_queue.sv
module vfzm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/vfzm_front.sv
module vfzm_front #(
   parameter int DIM_BITS = 16
) (
   input  logic [15:0]           canv_w,
   input  logic [15:0]           canv_h,
   input  logic [15:0]           tgt_w,
   input  logic [15:0]           tgt_h,
   input  logic                  view_mode,
   input  logic                  full_res_quality,
   input  logic [22:0]           zoom_q16,
   input  logic signed [39:0]    pan_x_q16,
   input  logic signed [39:0]    pan_y_q16,
   output vfzm_pkg::req_type     item
);
   import vfzm_pkg::*;

   function automatic logic dim_bad(input logic [DimW-1:0] d);
      return (d == '0) || ((d >> DIM_BITS) != '0);
   endfunction

   always_comb begin
      item.canv_w    = canv_w;
      item.canv_h    = canv_h;
      item.tgt_w     = tgt_w;
      item.tgt_h     = tgt_h;
      item.view_mode = mode_type'(view_mode);
      item.zoom_q16  = zoom_q16;
      item.pan_x_q16 = pan_x_q16;
      item.pan_y_q16 = pan_y_q16;
      // flag a request that the back end must answer with an invalid status
      item.invalid = dim_bad(canv_w) || dim_bad(canv_h) ||
                     dim_bad(tgt_w) || dim_bad(tgt_h) ||
                     !full_res_quality || (zoom_q16 < ZoomMin) || (zoom_q16 > ZoomMax);
   end

endmodule

>>> rtl/vfzm_back.sv
module vfzm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vfzm_pkg::req_type in_item,
   output logic              out_valid,
   output vfzm_pkg::rsp_type out_rsp
);
   import vfzm_pkg::*;

   // divider lanes, two quotient bits per stage
   logic                d_v_ff    [DivSteps];
   req_type             d_item_ff [DivSteps];
   logic [DimW-1:0]     d_rx_ff   [DivSteps];
   logic [DimW-1:0]     d_ry_ff   [DivSteps];
   logic [ScaleW-1:0]   d_qx_ff   [DivSteps];
   logic [ScaleW-1:0]   d_qy_ff   [DivSteps];
   logic [DimW-1:0]     d_rx_in   [DivSteps];
   logic [DimW-1:0]     d_ry_in   [DivSteps];
   logic [ScaleW-1:0]   d_qx_in   [DivSteps];
   logic [ScaleW-1:0]   d_qy_in   [DivSteps];

   always_comb begin
      for (int k = 0; k < DivSteps; k++) begin
         logic [DimW+1:0]   sx, sy;
         req_type           it;
         logic [DimW-1:0]   rx, ry;
         logic [ScaleW-1:0] qx, qy;
         logic [ScaleW-1:0] nx, ny;
         if (k == 0) begin
            it = in_item;
            rx = '0;
            ry = '0;
            qx = '0;
            qy = '0;
         end else begin
            it = d_item_ff[k-1];
            rx = d_rx_ff[k-1];
            ry = d_ry_ff[k-1];
            qx = d_qx_ff[k-1];
            qy = d_qy_ff[k-1];
         end
         nx = {it.tgt_w, 16'b0};
         ny = {it.tgt_h, 16'b0};
         sx = div_step2(rx, nx[ScaleW-1-2*k -: 2], it.canv_w);
         sy = div_step2(ry, ny[ScaleW-1-2*k -: 2], it.canv_h);
         d_rx_in[k] = sx[DimW-1:0];
         d_ry_in[k] = sy[DimW-1:0];
         d_qx_in[k] = {qx[ScaleW-3:0], sx[DimW+1:DimW]};
         d_qy_in[k] = {qy[ScaleW-3:0], sy[DimW+1:DimW]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DivSteps; k++) begin
         if (k == 0) begin
            d_item_ff[k] <= in_item;
         end else begin
            d_item_ff[k] <= d_item_ff[k-1];
         end
         d_rx_ff[k]   <= d_rx_in[k];
         d_ry_ff[k]   <= d_ry_in[k];
         d_qx_ff[k]   <= d_qx_in[k];
         d_qy_ff[k]   <= d_qy_in[k];
      end
   end

   // pick the scale
   logic              m_v_ff;
   req_type           m_item_ff;
   logic [ScaleW-1:0] m_scale_ff, m_scale_in;
   req_type           d_last;

   assign d_last = d_item_ff[DivSteps-1];

   always_comb begin
      if (d_last.view_mode == MODE_ZOOM) begin
         m_scale_in = ScaleW'(d_last.zoom_q16);
      end else if (d_qx_ff[DivSteps-1] < d_qy_ff[DivSteps-1]) begin
         m_scale_in = d_qx_ff[DivSteps-1];
      end else begin
         m_scale_in = d_qy_ff[DivSteps-1];
      end
   end

   always_ff @(posedge clock) begin
      m_item_ff  <= d_last;
      m_scale_ff <= m_scale_in;
   end

   // scaled canvas size
   logic              p_v_ff;
   req_type           p_item_ff;
   logic [ScaleW-1:0] p_scale_ff;
   logic [OutW-1:0]   p_w_ff, p_h_ff;

   always_ff @(posedge clock) begin
      p_item_ff  <= m_item_ff;
      p_scale_ff <= m_scale_ff;
      p_w_ff     <= m_item_ff.canv_w * m_scale_ff;
      p_h_ff     <= m_item_ff.canv_h * m_scale_ff;
   end

   // centering offset, halved toward minus infinity
   logic                    a_v_ff;
   req_type                 a_item_ff;
   logic [ScaleW-1:0]       a_scale_ff;
   logic [OutW-1:0]         a_w_ff, a_h_ff;
   logic signed [WideW-1:0] a_cx_ff, a_cy_ff;
   logic signed [WideW-1:0] dx, dy;

   always_comb begin
      dx = $signed({{(WideW-ScaleW){1'b0}}, p_item_ff.tgt_w, 16'b0})
           - $signed({2'b0, p_w_ff});
      dy = $signed({{(WideW-ScaleW){1'b0}}, p_item_ff.tgt_h, 16'b0})
           - $signed({2'b0, p_h_ff});
   end

   always_ff @(posedge clock) begin
      a_item_ff  <= p_item_ff;
      a_scale_ff <= p_scale_ff;
      a_w_ff     <= p_w_ff;
      a_h_ff     <= p_h_ff;
      a_cx_ff    <= dx >>> 1;
      a_cy_ff    <= dy >>> 1;
   end

   // add pan, check range, form the beat
   logic signed [WideW-1:0] left, top;
   logic                    ovf;

   always_comb begin
      left = a_cx_ff + WideW'(a_item_ff.pan_x_q16);
      top  = a_cy_ff + WideW'(a_item_ff.pan_y_q16);
      ovf  = (left[WideW-1:OutW-1] != '0 && left[WideW-1:OutW-1] != '1) ||
             (top[WideW-1:OutW-1] != '0 && top[WideW-1:OutW-1] != '1);
      out_rsp = '0;
      if (a_item_ff.invalid) begin
         out_rsp.status = STATUS_INVALID;
      end else if (ovf) begin
         out_rsp.status = STATUS_OVERFLOW;
      end else begin
         out_rsp.status             = STATUS_OK;
         out_rsp.scale_q16          = a_scale_ff;
         out_rsp.dest_left_q16      = left[OutW-1:0];
         out_rsp.dest_top_q16       = top[OutW-1:0];
         out_rsp.dest_width_q16     = a_w_ff;
         out_rsp.dest_height_q16    = a_h_ff;
         out_rsp.needs_intermediate = (a_scale_ff < OneQ16);
      end
   end

   assign out_valid = a_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivSteps; k++) begin
            d_v_ff[k] <= 1'b0;
         end
         m_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
      end else begin
         for (int k = 0; k < DivSteps; k++) begin
            if (k == 0) begin
               d_v_ff[k] <= in_valid;
            end else begin
               d_v_ff[k] <= d_v_ff[k-1];
            end
         end
         m_v_ff <= d_v_ff[DivSteps-1];
         p_v_ff <= m_v_ff;
         a_v_ff <= p_v_ff;
      end
   end

endmodule

>>> rtl/viewport_fit_zoom_mapper.sv
// Viewport fit/zoom mapper.
// Request channel (req_*): a queue input. A beat is taken on a rising edge
// with req_push high and req_full low. Each beat carries canvas and target
// sizes, view mode, raster-quality flag, zoom and pan.
// Response channel (rsp_*): a queue output. While rsp_empty is low the oldest
// response sits on the rsp_ ports; rsp_pop with rsp_empty low takes it.
// One response per request, in request order: scale, destination rectangle,
// needs_intermediate and a status (ok, invalid request, overflow).
// A request pushed into an empty block passes through the front queue,
// 16 divider stages (two quotient bits each, both axes in parallel),
// scale select, multiply, center, then the response queue. Throughput is
// one request per cycle while the credit count lets the front queue issue;
// the divider pipeline makes up most of the latency.
// The response queue holds 32 beats. Issue from the front queue is gated by
// a credit count of beats in flight plus beats waiting, so a stalled reader
// lets the pipeline drain into the queue; once it is full, req_full rises
// after the front queue fills. Reset empties both queues and the pipeline.
module viewport_fit_zoom_mapper #(
   parameter int DIM_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_canv_w,
   input  logic [15:0]        req_canv_h,
   input  logic [15:0]        req_tgt_w,
   input  logic [15:0]        req_tgt_h,
   input  logic               req_view_mode,
   input  logic               req_full_res_quality,
   input  logic [22:0]        req_zoom_q16,
   input  logic signed [39:0] req_pan_x_q16,
   input  logic signed [39:0] req_pan_y_q16,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_scale_q16,
   output logic signed [47:0] rsp_dest_left_q16,
   output logic signed [47:0] rsp_dest_top_q16,
   output logic [47:0]        rsp_dest_width_q16,
   output logic [47:0]        rsp_dest_height_q16,
   output logic               rsp_needs_intermediate
);
   import vfzm_pkg::*;

   localparam int MidDepth = 2;
   localparam int OutDepth = 32;
   localparam int CredW    = $clog2(OutDepth + 1);

   req_type  front_item, mid_item;
   logic     mid_empty, issue;
   logic     back_valid, out_full;
   rsp_type  back_rsp, out_rsp;
   logic     pop_acc;
   logic [CredW-1:0] credit_ff, credit_in;

   vfzm_front #(
      .DIM_BITS(DIM_BITS)
   ) u_front (
      .canv_w          (req_canv_w),
      .canv_h          (req_canv_h),
      .tgt_w           (req_tgt_w),
      .tgt_h           (req_tgt_h),
      .view_mode       (req_view_mode),
      .full_res_quality(req_full_res_quality),
      .zoom_q16        (req_zoom_q16),
      .pan_x_q16       (req_pan_x_q16),
      .pan_y_q16       (req_pan_y_q16),
      .item            (front_item)
   );

   // front queue: decouple intake from the back end's credit stall
   vfzm_queue #(
      .WIDTH($bits(req_type)),
      .DEPTH(MidDepth)
   ) u_mid_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (req_push),
      .wr_data(front_item),
      .rd_en  (issue),
      .rd_data(mid_item),
      .full   (req_full),
      .empty  (mid_empty)
   );

   // issue only with a free response slot reserved
   assign issue   = !mid_empty && (credit_ff < CredW'(OutDepth));
   assign pop_acc = rsp_pop && !rsp_empty;

   always_comb begin
      credit_in = credit_ff;
      if (issue && !pop_acc) begin
         credit_in = credit_ff + 1'b1;
      end else if (pop_acc && !issue) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   vfzm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue),
      .in_item  (mid_item),
      .out_valid(back_valid),
      .out_rsp  (back_rsp)
   );

   vfzm_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(OutDepth)
   ) u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (back_valid),
      .wr_data(back_rsp),
      .rd_en  (rsp_pop),
      .rd_data(out_rsp),
      .full   (out_full),
      .empty  (rsp_empty)
   );

   assign rsp_status             = out_rsp.status;
   assign rsp_scale_q16          = out_rsp.scale_q16;
   assign rsp_dest_left_q16      = out_rsp.dest_left_q16;
   assign rsp_dest_top_q16       = out_rsp.dest_top_q16;
   assign rsp_dest_width_q16     = out_rsp.dest_width_q16;
   assign rsp_dest_height_q16    = out_rsp.dest_height_q16;
   assign rsp_needs_intermediate = out_rsp.needs_intermediate;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CredW'(OutDepth))
      else $error("credit count above response queue depth");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      back_valid |-> !out_full)
      else $error("response written into full queue");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status != 2'd3))
      else $error("undefined status on response");

   a_credit_up: assert property (@(posedge clock) disable iff (reset)
      (issue && !pop_acc) |=> (credit_ff == $past(credit_ff) + 1'b1))
      else $error("credit not taken on issue");

endmodule

>>> bench/viewport_fit_zoom_mapper_tb.sv
`timescale 1ns / 1ps

module viewport_fit_zoom_mapper_tb;
   import vfzm_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainWait  = 40;

   // one request beat as the sender builds it
   typedef struct {
      logic [15:0]        cw;
      logic [15:0]        ch;
      logic [15:0]        tw;
      logic [15:0]        th;
      mode_type           mode;
      logic               full_q;
      logic [22:0]        zoom;
      logic signed [39:0] pan_x;
      logic signed [39:0] pan_y;
   } viewport_req_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [15:0]        req_canv_w;
   logic [15:0]        req_canv_h;
   logic [15:0]        req_tgt_w;
   logic [15:0]        req_tgt_h;
   logic               req_view_mode;
   logic               req_full_res_quality;
   logic [22:0]        req_zoom_q16;
   logic signed [39:0] req_pan_x_q16;
   logic signed [39:0] req_pan_y_q16;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [1:0]         rsp_status;
   logic [31:0]        rsp_scale_q16;
   logic signed [47:0] rsp_dest_left_q16;
   logic signed [47:0] rsp_dest_top_q16;
   logic [47:0]        rsp_dest_width_q16;
   logic [47:0]        rsp_dest_height_q16;
   logic               rsp_needs_intermediate;

   // expected responses, oldest first
   rsp_type mapped_rects[$];
   int      mismatch_count;
   int      cycle_count;
   int      hold_off_cycles;   // receiver stall requested by a test
   bit      pop_gaps_on;

   viewport_fit_zoom_mapper DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_canv_w(req_canv_w),
      .req_canv_h(req_canv_h),
      .req_tgt_w(req_tgt_w),
      .req_tgt_h(req_tgt_h),
      .req_view_mode(req_view_mode),
      .req_full_res_quality(req_full_res_quality),
      .req_zoom_q16(req_zoom_q16),
      .req_pan_x_q16(req_pan_x_q16),
      .req_pan_y_q16(req_pan_y_q16),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_scale_q16(rsp_scale_q16),
      .rsp_dest_left_q16(rsp_dest_left_q16),
      .rsp_dest_top_q16(rsp_dest_top_q16),
      .rsp_dest_width_q16(rsp_dest_width_q16),
      .rsp_dest_height_q16(rsp_dest_height_q16),
      .rsp_needs_intermediate(rsp_needs_intermediate)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Compute the mapped viewport for one request. Wide signed math keeps
   // every intermediate exact; the halving is an arithmetic shift, which
   // rounds toward minus infinity.
   function automatic rsp_type map_viewport(viewport_req_type r);
      rsp_type     m;
      longint unsigned sx, sy, scale, w, h;
      longint      left, top;
      m = '0;
      m.status = STATUS_OK;
      if (r.cw == 0 || r.ch == 0 || r.tw == 0 || r.th == 0 || !r.full_q ||
          r.zoom < 23'd1024 || r.zoom > 23'd4194304) begin
         m.status = STATUS_INVALID;
         return m;
      end
      if (r.mode == MODE_FIT) begin
         sx = (longint'(r.tw) << 16) / r.cw;
         sy = (longint'(r.th) << 16) / r.ch;
         scale = (sx < sy) ? sx : sy;
      end else begin
         scale = r.zoom;
      end
      w = r.cw * scale;
      h = r.ch * scale;
      left = ((longint'(r.tw) << 16) - longint'(w)) >>> 1;
      top  = ((longint'(r.th) << 16) - longint'(h)) >>> 1;
      left = left + longint'(r.pan_x);
      top  = top + longint'(r.pan_y);
      if (left < -(64'sd1 <<< 47) || left > (64'sd1 <<< 47) - 1 ||
          top < -(64'sd1 <<< 47) || top > (64'sd1 <<< 47) - 1) begin
         m.status = STATUS_OVERFLOW;
         return m;
      end
      m.scale_q16          = scale[31:0];
      m.dest_left_q16      = left[47:0];
      m.dest_top_q16       = top[47:0];
      m.dest_width_q16     = w[47:0];
      m.dest_height_q16    = h[47:0];
      m.needs_intermediate = (scale < 65536);
      return m;
   endfunction

   // Offer one beat from the falling edge; hold it until the block takes it.
   // req_full is stable between edges, so its value at the falling edge is
   // the one that counts at the next rising edge.
   task automatic send_req(viewport_req_type r);
      @(negedge clock);
      req_canv_w           = r.cw;
      req_canv_h           = r.ch;
      req_tgt_w            = r.tw;
      req_tgt_h            = r.th;
      req_view_mode        = r.mode;
      req_full_res_quality = r.full_q;
      req_zoom_q16         = r.zoom;
      req_pan_x_q16        = r.pan_x;
      req_pan_y_q16        = r.pan_y;
      req_push             = 1'b1;
      while (req_full) @(negedge clock);
      @(posedge clock);
      mapped_rects.push_back(map_viewport(r));
   endtask

   // Drop push for a random stretch: mostly short, now and then long.
   task automatic idle_sender();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (n == 0) return;
      @(negedge clock);
      req_push = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (mapped_rects.size() != 0) @(negedge clock);
   endtask

   function automatic viewport_req_type base_req();
      viewport_req_type r;
      r.cw = 16'd640;  r.ch = 16'd480;
      r.tw = 16'd1920; r.th = 16'd1080;
      r.mode = MODE_FIT; r.full_q = 1'b1;
      r.zoom = 23'd65536;
      r.pan_x = '0; r.pan_y = '0;
      return r;
   endfunction

   function automatic logic signed [39:0] rand_pan();
      case ($urandom_range(0, 3))
         0: return 40'({$urandom, $urandom});
         1: return 40'sd0 - 40'($urandom_range(0, 1 << 30));
         default: return 40'($urandom_range(0, 1 << 30));
      endcase
   endfunction

   // Random request: mostly valid, small sizes dominate, full-width values
   // and invalid fields mixed in.
   function automatic viewport_req_type rand_req();
      viewport_req_type r;
      r.cw = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      r.ch = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      r.tw = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      r.th = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      if ($urandom_range(0, 30) == 0) r.cw = '0;
      if ($urandom_range(0, 30) == 0) r.th = '0;
      r.mode   = mode_type'($urandom_range(0, 1));
      r.full_q = ($urandom_range(0, 15) != 0);
      case ($urandom_range(0, 9))
         0:       r.zoom = 23'($urandom);
         1:       r.zoom = 23'($urandom_range(0, 1100));
         default: r.zoom = 23'($urandom_range(1024, 4194304));
      endcase
      r.pan_x = rand_pan();
      r.pan_y = rand_pan();
      return r;
   endfunction

   task automatic test_fit_and_zoom_extremes();
      viewport_req_type r;
      r = base_req();                                        send_req(r);
      r.cw = 16'd1; r.ch = 16'd1; r.tw = 16'hFFFF; r.th = 16'hFFFF; send_req(r);
      r = base_req(); r.cw = 16'hFFFF; r.ch = 16'hFFFF; r.tw = 16'd1; r.th = 16'd1;
      send_req(r);                                           // deep downscale
      r = base_req(); r.tw = 16'd641; r.th = 16'd3;          send_req(r); // odd target sizes
      r = base_req(); r.mode = MODE_ZOOM; r.zoom = 23'd1024; send_req(r);
      r.zoom = 23'd4194304;                                  send_req(r);
      r.zoom = 23'd65535;                                    send_req(r);
      r.zoom = 23'd65536;                                    send_req(r);
      r = base_req(); r.pan_x = 40'sh7F_FFFF_FFFF; r.pan_y = 40'sh80_0000_0000;
      send_req(r);
   endtask

   task automatic test_invalid_requests();
      viewport_req_type r;
      r = base_req(); r.cw = '0;             send_req(r);
      r = base_req(); r.ch = '0;             send_req(r);
      r = base_req(); r.tw = '0;             send_req(r);
      r = base_req(); r.th = '0;             send_req(r);
      r = base_req(); r.full_q = 1'b0;       send_req(r);
      r = base_req(); r.zoom = 23'd1023;     send_req(r);   // checked in fit mode too
      r.mode = MODE_ZOOM; r.zoom = 23'd4194305; send_req(r);
      r.zoom = 23'h7FFFFF;                   send_req(r);
      r.zoom = '0;                           send_req(r);
   endtask

   task automatic test_overflow();
      viewport_req_type r;
      // largest zoomed canvas in a tiny target with extreme pans: the edges
      // reach about 2^39 and still sit well inside the output range
      r = base_req(); r.mode = MODE_ZOOM; r.zoom = 23'd4194304;
      r.cw = 16'hFFFF; r.ch = 16'hFFFF; r.tw = 16'd1; r.th = 16'd1;
      r.pan_x = 40'sh80_0000_0000;           send_req(r);
      r.pan_x = '0; r.pan_y = 40'sh80_0000_0000; send_req(r);
      r.pan_y = '0;                          send_req(r);
      r.pan_x = 40'sh7F_FFFF_FFFF;           send_req(r);
   endtask

   task automatic test_random_traffic(int count);
      for (int i = 0; i < count; i++) begin
         send_req(rand_req());
         if ($urandom_range(0, 99) < 70) idle_sender();
         if (i % 150 == 60) begin
            // run a stretch with no gaps on either side
            pop_gaps_on = 1'b0;
            for (int k = 0; k < 40; k++) send_req(rand_req());
            pop_gaps_on = 1'b1;
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 300;
      for (int i = 0; i < 80; i++) send_req(rand_req());
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 10; i++) send_req(rand_req());
      wait_drained();
      for (int i = 0; i < 10; i++) send_req(rand_req());
   endtask

   // Receiver: decide pop at the falling edge, honor any requested hold-off.
   initial begin
      int gap;
      gap = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_pop = 1'b0;
            hold_off_cycles--;
         end else if (gap > 0) begin
            rsp_pop = 1'b0;
            gap--;
         end else begin
            rsp_pop = 1'b1;
            if (pop_gaps_on && $urandom_range(0, 99) < 30)
               gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
         end
      end
   end

   // Check each accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (mapped_rects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response beat with nothing expected", $time);
         end else begin
            want = mapped_rects.pop_front();
            if (rsp_status !== want.status || rsp_scale_q16 !== want.scale_q16 ||
                rsp_dest_left_q16 !== want.dest_left_q16 ||
                rsp_dest_top_q16 !== want.dest_top_q16 ||
                rsp_dest_width_q16 !== want.dest_width_q16 ||
                rsp_dest_height_q16 !== want.dest_height_q16 ||
                rsp_needs_intermediate !== want.needs_intermediate) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch status %0d/%0d scale %h/%h", $time,
                           want.status, rsp_status, want.scale_q16, rsp_scale_q16);
                  $display("   left %h/%h top %h/%h", want.dest_left_q16,
                           rsp_dest_left_q16, want.dest_top_q16, rsp_dest_top_q16);
                  $display("   w %h/%h h %h/%h ni %b/%b", want.dest_width_q16,
                           rsp_dest_width_q16, want.dest_height_q16,
                           rsp_dest_height_q16, want.needs_intermediate,
                           rsp_needs_intermediate);
               end
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      mismatch_count       = 0;
      cycle_count          = 0;
      hold_off_cycles      = 0;
      pop_gaps_on          = 1'b1;
      reset                = 1'b1;
      req_push             = 1'b0;
      req_canv_w           = '0;
      req_canv_h           = '0;
      req_tgt_w            = '0;
      req_tgt_h            = '0;
      req_view_mode        = 1'b0;
      req_full_res_quality = 1'b0;
      req_zoom_q16         = '0;
      req_pan_x_q16        = '0;
      req_pan_y_q16        = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fit_and_zoom_extremes();
      test_invalid_requests();
      test_overflow();
      test_random_traffic(340);
      test_backpressure();
      test_pause_until_drained();

      // hold until every expected beat has come, then let the pipe settle
      wait_drained();
      repeat (DrainWait) @(negedge clock);
      if (mismatch_count == 0 && mapped_rects.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
